>>> rtl/mddc_pkg.sv
`timescale 1ns / 1ps

package mddc_pkg;

    localparam int WINDOW      = 5;
    localparam int DIST_BITS   = 10;
    localparam int REG_BITS    = 10;
    localparam int SAMPLE_BITS = 10;
    localparam int CMP_BITS    = (DIST_BITS > REG_BITS) ? DIST_BITS : REG_BITS;
    localparam int IDX_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW + 1);
    localparam int MEDIAN_RANK = WINDOW / 2;
    localparam int STEP_BITS   = 3;
    localparam int CFG_ADDR_BITS = 2;
    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 16;

    localparam logic [REG_BITS-1:0] MAX_VALID_RESET = REG_BITS'(300);
    localparam logic [REG_BITS-1:0] OPEN_RESET      = REG_BITS'(40);
    localparam logic [REG_BITS-1:0] CAR_IN_RESET    = REG_BITS'(180);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MAX_VALID = 2'd0,
        REG_OPEN      = 2'd1,
        REG_CAR_IN    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_INIT    = 2'd0,
        CLASS_OPEN    = 2'd1,
        CLASS_CAR_IN  = 2'd2,
        CLASS_CAR_OUT = 2'd3
    } door_class_t;

    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_CMP   = 3'd2,
        OP_CLASS = 3'd3,
        OP_EMIT  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT   = 2'd0,
        COND_REJECT = 2'd1,
        COND_LOOP   = 2'd2,
        COND_ALWAYS = 2'd3
    } cond_t;

    typedef logic [STEP_BITS-1:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_LOAD  = 3'd1;
    localparam step_t STEP_CMP   = 3'd2;
    localparam step_t STEP_CLASS = 3'd3;
    localparam step_t STEP_EMIT  = 3'd4;

    function automatic ctrl_word_t prog_word(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_REJECT, target: STEP_EMIT};
            STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_NEXT,   target: STEP_WAIT};
            STEP_CMP:   w = '{op: OP_CMP,   cond: COND_LOOP,   target: STEP_CMP};
            STEP_CLASS: w = '{op: OP_CLASS, cond: COND_NEXT,   target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_ALWAYS, target: STEP_WAIT};
            default:    w = '{op: OP_EMIT,  cond: COND_ALWAYS, target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/median_distance_door_classifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_        in         tdata[9:0] distance_sample
// m_        out        tdata[1:0] door_class, [2] class_changed, [3] sample_accepted,
//                      [13:4] median_distance
// cfg_      in         index 0 max_valid_distance, 1 open_below, 2 car_in_below
//
// An accepted sample passes WAIT, LOAD, CMP, CLASS and EMIT from input beat to output beat;
// one comparator ranks every window entry against every other.
// A rejected sample goes from WAIT straight to EMIT. One sample is worked on at a time.
// The next input beat is taken once the output register is free or being drained.
// Reset is synchronous, active low: clears window, median, class, flags; loads thresholds.

module median_distance_door_classifier (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mddc_pkg::S_TDATA_BITS-1:0]      s_tdata,   // [9:0] distance_sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mddc_pkg::M_TDATA_BITS-1:0]      m_tdata,   // class, changed, accepted, median
    input  logic                                   cfg_wr_en,
    input  logic [mddc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [mddc_pkg::REG_BITS-1:0]          cfg_wdata
);
    import mddc_pkg::*;

    typedef logic [DIST_BITS-1:0] dist_t;

    ctrl_word_t  cw;
    step_t       step_reg, step_next;
    dist_t       win_reg [WINDOW];
    dist_t       win_next [WINDOW];
    dist_t       a_reg [WINDOW];
    dist_t       a_next [WINDOW];
    dist_t       b_reg [WINDOW];
    dist_t       b_next [WINDOW];
    logic [IDX_BITS-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_BITS-1:0] lt_reg, lt_next, le_reg, le_next, lt_sum, le_sum;
    dist_t       med_reg, med_next, last_median_reg, last_median_next;
    door_class_t class_reg, class_next, new_class;
    logic        changed_reg, changed_next, accepted_reg, accepted_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_data_reg, m_data_next;
    logic [REG_BITS-1:0] max_valid_reg, open_reg, car_in_reg;
    logic [SAMPLE_BITS-1:0] sample;
    logic        in_beat, sample_ok, out_busy, hold, jump, row_end, last_pair;
    logic [CMP_BITS-1:0] med_wide;

    assign cw        = prog_word(step_reg);
    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign sample_ok = (sample <= max_valid_reg);
    assign out_busy  = m_valid_reg && !m_tready;
    assign s_tready  = (cw.op == OP_WAIT) && !out_busy;
    assign in_beat   = s_tvalid && s_tready;
    assign row_end   = (j_reg == IDX_BITS'(WINDOW - 1));
    assign last_pair = row_end && (i_reg == IDX_BITS'(WINDOW - 1));
    assign lt_sum    = lt_reg + CNT_BITS'(b_reg[0] <  a_reg[0]);
    assign le_sum    = le_reg + CNT_BITS'(b_reg[0] <= a_reg[0]);
    assign med_wide  = CMP_BITS'(med_reg);

    always_comb begin
        if (med_wide < CMP_BITS'(open_reg)) begin
            new_class = CLASS_OPEN;
        end else if (med_wide < CMP_BITS'(car_in_reg)) begin
            new_class = CLASS_CAR_IN;
        end else begin
            new_class = CLASS_CAR_OUT;
        end
    end

    always_comb begin
        unique case (cw.op)
            OP_WAIT: hold = !in_beat;
            OP_EMIT: hold = out_busy;
            default: hold = 1'b0;
        endcase
        unique case (cw.cond)
            COND_REJECT: jump = !sample_ok;
            COND_LOOP:   jump = !last_pair;
            COND_ALWAYS: jump = 1'b1;
            default:     jump = 1'b0;
        endcase
        if (hold) begin
            step_next = step_reg;
        end else if (jump) begin
            step_next = cw.target;
        end else begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_comb begin
        win_next         = win_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        lt_next          = lt_reg;
        le_next          = le_reg;
        med_next         = med_reg;
        last_median_next = last_median_reg;
        class_next       = class_reg;
        changed_next     = changed_reg;
        accepted_next    = accepted_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        unique case (cw.op)
            OP_WAIT: begin
                if (in_beat) begin
                    accepted_next = sample_ok;
                    changed_next  = 1'b0;
                    if (sample_ok) begin
                        win_next[0] = DIST_BITS'(sample);
                        for (int k = 1; k < WINDOW; k++) begin
                            win_next[k] = win_reg[k-1];
                        end
                    end
                end
            end
            OP_LOAD: begin
                a_next  = win_reg;
                b_next  = win_reg;
                i_next  = '0;
                j_next  = '0;
                lt_next = '0;
                le_next = '0;
            end
            OP_CMP: begin
                for (int k = 0; k < WINDOW; k++) begin
                    b_next[k] = b_reg[(k + 1) % WINDOW];
                end
                if (row_end) begin
                    if (lt_sum <= CNT_BITS'(MEDIAN_RANK) && le_sum > CNT_BITS'(MEDIAN_RANK)) begin
                        med_next = a_reg[0];
                    end
                    for (int k = 0; k < WINDOW; k++) begin
                        a_next[k] = a_reg[(k + 1) % WINDOW];
                    end
                    j_next  = '0;
                    i_next  = i_reg + IDX_BITS'(1);
                    lt_next = '0;
                    le_next = '0;
                end else begin
                    j_next  = j_reg + IDX_BITS'(1);
                    lt_next = lt_sum;
                    le_next = le_sum;
                end
            end
            OP_CLASS: begin
                class_next       = new_class;
                changed_next     = (new_class != class_reg);
                last_median_next = med_reg;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_BITS'({REG_BITS'(last_median_reg), accepted_reg,
                                                  changed_reg, class_reg});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= STEP_WAIT;
            for (int k = 0; k < WINDOW; k++) begin
                win_reg[k] <= '0;
            end
            last_median_reg <= '0;
            class_reg       <= CLASS_INIT;
            changed_reg     <= 1'b0;
            accepted_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_valid_reg   <= MAX_VALID_RESET;
            open_reg        <= OPEN_RESET;
            car_in_reg      <= CAR_IN_RESET;
        end else begin
            step_reg        <= step_next;
            win_reg         <= win_next;
            last_median_reg <= last_median_next;
            class_reg       <= class_next;
            changed_reg     <= changed_next;
            accepted_reg    <= accepted_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MAX_VALID: max_valid_reg <= cfg_wdata;
                    REG_OPEN:      open_reg      <= cfg_wdata;
                    REG_CAR_IN:    car_in_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lt_reg     <= lt_next;
        le_reg     <= le_next;
        med_reg    <= med_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> bench/median_distance_door_classifier_tb.sv
`timescale 1ns / 1ps

module median_distance_door_classifier_tb;
    import mddc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 165;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_ADDR = 2'd3;

    // The first member lands in the highest bits, so door_class is last.
    typedef struct packed {
        logic [DIST_BITS-1:0] median_distance;
        logic                 sample_accepted;
        logic                 class_changed;
        door_class_t          door_class;
    } door_result_t;

    class door_scoreboard;
        logic [REG_BITS-1:0]  max_valid;
        logic [REG_BITS-1:0]  open_below;
        logic [REG_BITS-1:0]  car_in_below;
        logic [DIST_BITS-1:0] ring [WINDOW];
        int                   slot;
        door_class_t          cls;
        logic [DIST_BITS-1:0] held_median;
        door_result_t         pending [$];
        int                   errors;

        function new();
            max_valid    = MAX_VALID_RESET;
            open_below   = OPEN_RESET;
            car_in_below = CAR_IN_RESET;
            foreach (ring[i]) ring[i] = '0;
            slot        = 0;
            cls         = CLASS_INIT;
            held_median = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [REG_BITS-1:0] value);
            case (addr)
                REG_MAX_VALID: max_valid    = value;
                REG_OPEN:      open_below   = value;
                REG_CAR_IN:    car_in_below = value;
                default: ;
            endcase
        endfunction

        // The median is the entry whose rank span covers the middle position.
        function logic [DIST_BITS-1:0] window_median();
            int less;
            int same;
            for (int i = 0; i < WINDOW; i++) begin
                less = 0;
                same = 0;
                for (int k = 0; k < WINDOW; k++) begin
                    if (ring[k] < ring[i]) less++;
                    else if (ring[k] == ring[i]) same++;
                end
                if (less <= MEDIAN_RANK && MEDIAN_RANK < less + same) return ring[i];
            end
            return ring[0];
        endfunction

        function void note_sample(logic [DIST_BITS-1:0] sample_value);
            door_result_t r;
            door_class_t  next_cls;
            r.class_changed   = 1'b0;
            r.sample_accepted = 1'b0;
            if (sample_value <= max_valid) begin
                ring[slot]  = sample_value;
                slot        = (slot == WINDOW - 1) ? 0 : slot + 1;
                held_median = window_median();
                if (held_median < open_below) next_cls = CLASS_OPEN;
                else if (held_median < car_in_below) next_cls = CLASS_CAR_IN;
                else next_cls = CLASS_CAR_OUT;
                r.class_changed   = (next_cls != cls);
                r.sample_accepted = 1'b1;
                cls               = next_cls;
            end
            r.door_class      = cls;
            r.median_distance = held_median;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] beat);
            door_result_t got;
            door_result_t want;
            got = door_result_t'(beat[$bits(door_result_t)-1:0]);
            if (pending.size() == 0) begin
                $display("%0t: result beat expected none, actual %h", $time, beat);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("door_class", want.door_class, got.door_class);
            compare_field("class_changed", want.class_changed, got.class_changed);
            compare_field("sample_accepted", want.sample_accepted, got.sample_accepted);
            compare_field("median_distance", want.median_distance, got.median_distance);
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
    logic [REG_BITS-1:0]       cfg_wdata = '0;

    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             stall_cycles = 0;
    door_scoreboard sb = new();

    median_distance_door_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn || (m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("median_distance_door_classifier verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // All tasks start and end at a falling edge.
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [REG_BITS-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(addr, value);
    endtask

    task automatic write_thresholds(input int max_valid, input int open_below,
                                    input int car_in_below);
        write_reg(REG_MAX_VALID, REG_BITS'(max_valid));
        write_reg(REG_OPEN, REG_BITS'(open_below));
        write_reg(REG_CAR_IN, REG_BITS'(car_in_below));
    endtask

    task automatic send_sample(input logic [DIST_BITS-1:0] sample_value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_BITS'(sample_value);
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(sample_value);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    // Most samples sit near a threshold so the median keeps crossing it.
    function automatic logic [DIST_BITS-1:0] pick_sample();
        int base;
        if ($urandom_range(9) < 2) return DIST_BITS'($urandom_range(1023));
        case ($urandom_range(2))
            0:       base = sb.open_below;
            1:       base = sb.car_in_below;
            default: base = sb.max_valid;
        endcase
        base = base + int'($urandom_range(16)) - 8;
        if (base < 0) base = 0;
        if (base > 1023) base = 1023;
        return DIST_BITS'(base);
    endfunction

    task automatic apply_setting(input int which);
        case (which)
            0: write_thresholds(300, 40, 180);
            1: write_thresholds(1023, 0, 1023);
            2: write_thresholds(1023, 1023, 0);
            3: write_thresholds($urandom_range(1023), $urandom_range(1023),
                                $urandom_range(1023));
            4: write_thresholds(600, 500, 100);
            default: write_thresholds($urandom_range(60), $urandom_range(30),
                                      $urandom_range(60));
        endcase
    endtask

    task automatic run_directed();
        send_sample(0);
        send_sample(1023);
        send_sample(301);
        send_sample(300);
        send_sample(200);
        send_sample(250);
        send_sample(40);
        send_sample(39);
        send_sample(179);
        send_sample(180);
        send_sample(180);
        send_sample(180);
        drain_results();
        write_thresholds(1023, 0, 1023);
        repeat (3) send_sample(1023);
        repeat (3) send_sample(1022);
        drain_results();
        write_reg(CFG_SPARE_ADDR, 10'h3FF);
        write_thresholds(0, 1023, 0);
        send_sample(1);
        repeat (3) send_sample(0);
        send_sample(512);
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run_directed();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 36;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            apply_setting(phase);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(199) == 0) drain_results();
                send_sample(pick_sample());
            end
            drain_results();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("median_distance_door_classifier verification clean");
        end else begin
            $display("median_distance_door_classifier verification failed");
        end
        $finish;
    end

endmodule

>>> median_distance_door_classifier.f
rtl/mddc_pkg.sv
rtl/median_distance_door_classifier.sv
bench/median_distance_door_classifier_tb.sv
